// File: rtl/assert_macros.svh
// Assertion helpers for the RTL; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, idle during rst
`define PNDL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pndl assertion failed");

// Next-cycle implication, sampled on clk, idle during rst
`define PNDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pndl assertion failed");

`else

`define PNDL_ASSERT_NOW(lbl, ante, cons)
`define PNDL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/pndl_pkg.sv
package pndl_pkg;

  // Fixed result field widths
  localparam int DIV_W = 15;
  localparam int SUM_W = 18;

  // Saturation value of the aliquot_sum field
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_DIV   = 3'b100
  } pndl_state_t;

  // Status from the remainder unit to the sequencer
  typedef struct packed {
    logic done;   // one-cycle pulse, remainder ready
    logic zero;   // remainder is zero (valid with done)
  } pndl_mod_status_t;

endpackage

// File: rtl/perfect_number_divisor_lister.sv
// Perfect-number tester. Pulse start while busy is low to hand in one word
// (number). busy drops in the cycle that shows the last result word, so the
// next word can be handed in at the edge that ends it. Every candidate
// d = 1..n-1 is tried by a bit-serial remainder unit. For each candidate the
// sequencer issues it, the unit loads it, shifts in the NUMBER_WIDTH dividend
// bits one by one and the sequencer then takes the remainder. A non-perfect
// number gives one result word after one pass. A perfect number takes a second
// pass that emits its proper divisors in ascending order, each one once the
// next divisor is found and the final one at the end of the pass. Each result
// word is on the outputs for exactly one cycle, marked by strobe; the receiver
// cannot stall the block, so it must take every word as it is shown.
`include "assert_macros.svh"

module perfect_number_divisor_lister #(
  parameter int NUMBER_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [NUMBER_WIDTH-1:0]       number,
  output logic                          busy,
  output logic                          strobe,
  output logic                          is_perfect,
  output logic [pndl_pkg::DIV_W-1:0]    divisor,
  output logic [pndl_pkg::SUM_W-1:0]    aliquot_sum,
  output logic                          last
);
  import pndl_pkg::*;

  localparam int W  = NUMBER_WIDTH;
  localparam int SW = W + 3;                      // exact aliquot sum
  localparam int CW = (SW > SUM_W) ? SW : SUM_W;  // saturation compare
  localparam int XW = (W > DIV_W) ? W : DIV_W;    // divisor field extend

  pndl_state_t      state;
  logic [W-1:0]     n;
  logic [W-1:0]     d;
  logic [SW-1:0]    sum;
  logic             pass;       // 0: summing, 1: listing divisors
  logic [W-1:0]     held;       // divisor waiting for its successor
  logic             have_held;
  logic             mod_start;
  pndl_mod_status_t mod_status;

  logic [CW-1:0]    sum_x;
  logic [SUM_W-1:0] sum_field;
  logic [XW-1:0]    held_x;
  logic             perfect;

  pndl_mod_unit #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (n),
    .divisor  (d),
    .status   (mod_status)
  );

  // Field formatting
  always_comb begin
    sum_x     = CW'(sum);
    sum_field = (sum_x > CW'(SUM_MAX)) ? SUM_MAX : sum_x[SUM_W-1:0];
    held_x    = XW'(held);
    perfect   = (n != '0) && (sum == SW'(n));
  end

  assign busy = (state != S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      strobe    <= 1'b0;
      mod_start <= 1'b0;
      have_held <= 1'b0;
      pass      <= 1'b0;
    end else begin
      strobe    <= 1'b0;
      mod_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            n         <= number;
            d         <= W'(1);
            sum       <= '0;
            pass      <= 1'b0;
            have_held <= 1'b0;
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (d < n) begin
            mod_start <= 1'b1;
            state     <= S_DIV;
          end else if (!pass) begin
            if (perfect) begin
              // rerun the candidates to list the divisors
              pass  <= 1'b1;
              d     <= W'(1);
              state <= S_CHECK;
            end else begin
              strobe      <= 1'b1;
              is_perfect  <= 1'b0;
              divisor     <= '0;
              aliquot_sum <= sum_field;
              last        <= 1'b1;
              state       <= S_IDLE;
            end
          end else begin
            // flush the final divisor
            strobe      <= 1'b1;
            is_perfect  <= 1'b1;
            divisor     <= held_x[DIV_W-1:0];
            aliquot_sum <= sum_field;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_DIV: begin
          if (mod_status.done) begin
            if (mod_status.zero) begin
              if (!pass) begin
                sum <= sum + SW'(d);
              end else begin
                if (have_held) begin
                  strobe      <= 1'b1;
                  is_perfect  <= 1'b1;
                  divisor     <= held_x[DIV_W-1:0];
                  aliquot_sum <= sum_field;
                  last        <= 1'b0;
                end
                held      <= d;
                have_held <= 1'b1;
              end
            end
            d     <= d + W'(1);
            state <= S_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `PNDL_ASSERT_NOW(a_np_single, strobe && !is_perfect, last && (divisor == '0))
  `PNDL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `PNDL_ASSERT_NEXT(a_last_gap, strobe && last, !strobe)
  `PNDL_ASSERT_NOW(a_done_in_div, mod_status.done, state == S_DIV)

endmodule

// File: rtl/pndl_mod_unit.sv
// Bit-serial restoring remainder: one dividend bit shifted in per cycle.
module pndl_mod_unit #(
  parameter int NUMBER_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [NUMBER_WIDTH-1:0]       dividend,
  input  logic [NUMBER_WIDTH-1:0]       divisor,
  output pndl_pkg::pndl_mod_status_t    status
);
  import pndl_pkg::*;

  localparam int W     = NUMBER_WIDTH;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     dvd;
  logic [W-1:0]     dsr;
  logic [W-1:0]     rem;
  logic [W-1:0]     rem_next;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic             done;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             ge;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, dvd[W-1]};
    diff     = trial - {1'b0, dsr};
    ge       = (trial >= {1'b0, dsr});
    rem_next = ge ? diff[W-1:0] : trial[W-1:0];
  end

  // Control: bit counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (running) begin
      dvd <= {dvd[W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign status.done = done;
  assign status.zero = (rem == '0);

endmodule
